FILE: src/xlb_pkg.sv
// ---------------------------------------------------------------------------
// xlb_pkg
// shared codes, field widths and types for the xor linear basis engine
// ---------------------------------------------------------------------------
package xlb_pkg;

    // fixed field widths of the item and result channels
    localparam int unsigned VALUE_W = 31;
    localparam int unsigned MAX_W   = 31;
    localparam int unsigned RANK_W  = 5;

    typedef logic [1:0] t_action;

    localparam t_action ACT_INSERT = 2'd0;
    localparam t_action ACT_CHECK  = 2'd1;
    localparam t_action ACT_CLEAR  = 2'd2;

    // operating mode of the shared step unit
    typedef logic t_mode;

    localparam t_mode MODE_REDUCE = 1'b0;
    localparam t_mode MODE_MAX    = 1'b1;

    // step unit control in, status out
    typedef struct packed {
        t_mode mode;
        logic  slot_valid;
    } t_step_ctrl;

    typedef struct packed {
        logic hit_empty;
        logic took;
    } t_step_stat;

endpackage

FILE: src/xlb_ram.sv
// ---------------------------------------------------------------------------
// xlb_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module xlb_ram #(
    parameter int unsigned WIDTH = 31,
    parameter int unsigned DEPTH = 31
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/xlb_step_unit.sv
// ---------------------------------------------------------------------------
// xlb_step_unit
// one slot step: reduce the working word or fold a slot into the max
// ---------------------------------------------------------------------------
module xlb_step_unit #(
    parameter int unsigned WORD_BITS = 31
) (
    input  xlb_pkg::t_step_ctrl              i_ctrl,
    input  logic [WORD_BITS-1:0]             i_acc,
    input  logic [WORD_BITS-1:0]             i_slot,
    input  logic [$clog2(WORD_BITS)-1:0]     i_idx,
    output logic [WORD_BITS-1:0]             o_acc,
    output xlb_pkg::t_step_stat              o_stat
);

    logic [WORD_BITS-1:0] w_cand;
    logic                 w_lead;

    assign w_cand = i_acc ^ i_slot;
    assign w_lead = i_acc[i_idx];

    always_comb begin
        o_acc  = i_acc;
        o_stat = '0;
        unique case (i_ctrl.mode)
            xlb_pkg::MODE_REDUCE: begin
                // leading bit set: cancel it with the slot, or report the empty slot
                if (w_lead) begin
                    if (i_ctrl.slot_valid) begin
                        o_acc       = w_cand;
                        o_stat.took = 1'b1;
                    end else begin
                        o_stat.hit_empty = 1'b1;
                    end
                end
            end
            xlb_pkg::MODE_MAX: begin
                // greedy: take the slot when it raises the total
                if (w_cand > i_acc) begin
                    o_acc       = w_cand;
                    o_stat.took = 1'b1;
                end
            end
            default: begin
                o_acc = i_acc;
            end
        endcase
    end

endmodule

FILE: src/xor_linear_basis_engine_core.sv
// ---------------------------------------------------------------------------
// xor_linear_basis_engine_core
// gf(2) linear basis of words, one slot per leading bit, with insert,
// membership check, clear, greedy maximum xor and rank
// ---------------------------------------------------------------------------
// usage
//   input channel (i_valid / o_ready) carries i_action and i_value; output
//   channel (o_valid / i_ready) carries o_in_span, o_max_xor and o_rank.
//   every input transfer yields exactly one output transfer.
//   one item at a time: o_ready is high only while the sequencer is idle.
// sequence
//   insert and check walk the slots from the top bit down, one slot per
//   cycle, ending early when an empty slot is hit; then the prime state
//   re-primes the slot ram read, then the greedy maximum walks all
//   WORD_BITS slots and the result is held in the output state. clear and
//   unused codes skip the reduction.
//   the rate is set by the single read port of the slot ram and the shared
//   step unit, both used once per cycle.
// reset
//   synchronous active-low reset empties the basis (all slot valid bits and
//   the rank cleared at once, no sweep) and returns the sequencer to idle.
// stall
//   the result is held in registers until i_ready; no new item is taken
//   before the result transfer completes.
// ---------------------------------------------------------------------------
module xor_linear_basis_engine_core #(
    parameter int unsigned WORD_BITS = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  xlb_pkg::t_action              i_action,
    input  logic [xlb_pkg::VALUE_W-1:0]   i_value,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_in_span,
    output logic [xlb_pkg::MAX_W-1:0]     o_max_xor,
    output logic [xlb_pkg::RANK_W-1:0]    o_rank
);

    localparam int unsigned IW = $clog2(WORD_BITS);
    localparam int unsigned RW = $clog2(WORD_BITS + 1);
    localparam logic [IW-1:0] TOP_IDX = IW'(WORD_BITS - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RED   = 3'd1;
    localparam logic [2:0] S_PRIME = 3'd2;
    localparam logic [2:0] S_MAX   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [WORD_BITS-1:0] r_valid, n_valid;   // slot occupied flags
    logic [RW-1:0]        r_rank,  n_rank;
    logic [WORD_BITS-1:0] r_acc,   n_acc;     // residue, then running max
    logic [IW-1:0]        r_idx,   n_idx;     // slot whose data sits on the ram output
    logic                 r_span,  n_span;
    xlb_pkg::t_action     r_act,   n_act;

    logic                 w_accept;
    logic [WORD_BITS-1:0] w_value;
    logic [WORD_BITS-1:0] w_rdata;
    logic [WORD_BITS-1:0] w_slot;
    logic [IW-1:0]        w_raddr;
    logic                 w_we;
    logic [WORD_BITS-1:0] w_next_acc;
    xlb_pkg::t_step_ctrl  w_ctrl;
    xlb_pkg::t_step_stat  w_stat;

    assign w_accept = i_valid && o_ready;
    assign w_value  = WORD_BITS'(i_value);

    // an empty slot reads as zero whatever the ram holds
    assign w_slot = r_valid[r_idx] ? w_rdata : '0;

    assign w_ctrl.mode       = (r_state == S_MAX) ? xlb_pkg::MODE_MAX : xlb_pkg::MODE_REDUCE;
    assign w_ctrl.slot_valid = r_valid[r_idx];

    xlb_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_BITS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx),
        .i_wdata (r_acc),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    xlb_step_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_step (
        .i_ctrl (w_ctrl),
        .i_acc  (r_acc),
        .i_slot (w_slot),
        .i_idx  (r_idx),
        .o_acc  (w_next_acc),
        .o_stat (w_stat)
    );

    // sequencer: the read for the next lower slot is issued while the
    // current slot is processed
    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        n_rank  = r_rank;
        n_acc   = r_acc;
        n_idx   = r_idx;
        n_span  = r_span;
        n_act   = r_act;
        w_we    = 1'b0;
        w_raddr = r_idx - IW'(1);
        unique case (r_state)
            S_IDLE: begin
                w_raddr = TOP_IDX;
                if (w_accept) begin
                    n_act  = i_action;
                    n_idx  = TOP_IDX;
                    n_span = 1'b0;
                    unique case (i_action)
                        xlb_pkg::ACT_INSERT, xlb_pkg::ACT_CHECK: begin
                            n_acc   = w_value;
                            n_state = S_RED;
                        end
                        xlb_pkg::ACT_CLEAR: begin
                            n_valid = '0;
                            n_rank  = '0;
                            n_acc   = '0;
                            n_state = S_MAX;
                        end
                        default: begin
                            // unused code: report the basis as it stands
                            n_acc   = '0;
                            n_state = S_MAX;
                        end
                    endcase
                end
            end
            S_RED: begin
                if (w_stat.hit_empty) begin
                    // residue not in span; insert stores it in its own slot
                    if (r_act == xlb_pkg::ACT_INSERT) begin
                        w_we           = 1'b1;
                        n_valid[r_idx] = 1'b1;
                        n_rank         = r_rank + RW'(1);
                    end
                    n_span  = 1'b0;
                    n_state = S_PRIME;
                end else begin
                    n_acc = w_next_acc;
                    if (r_idx == '0) begin
                        n_span  = (w_next_acc == '0);
                        n_state = S_PRIME;
                    end else begin
                        n_idx = r_idx - IW'(1);
                    end
                end
            end
            S_PRIME: begin
                // refetch the top slot after any write has landed
                w_raddr = TOP_IDX;
                n_idx   = TOP_IDX;
                n_acc   = '0;
                n_state = S_MAX;
            end
            S_MAX: begin
                n_acc = w_next_acc;
                if (r_idx == '0) begin
                    w_raddr = TOP_IDX;
                    n_state = S_OUT;
                end else begin
                    n_idx = r_idx - IW'(1);
                end
            end
            S_OUT: begin
                w_raddr = TOP_IDX;
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_rank  <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_rank  <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_idx  <= n_idx;
        r_span <= n_span;
        r_act  <= n_act;
    end

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = (r_state == S_OUT);
    assign o_in_span = r_span;
    assign o_max_xor = xlb_pkg::MAX_W'(r_acc);
    assign o_rank    = xlb_pkg::RANK_W'(r_rank);

    // rank always matches the number of occupied slots
    a_rank_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_rank))
        else $error("rank out of step with occupied slots");

    // a slot is written only while empty, and only on insert
    a_write_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (!r_valid[r_idx] && r_act == xlb_pkg::ACT_INSERT))
        else $error("slot overwritten");

    // no item is taken while a result waits
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("item taken while result pending");

    // after a clear transfer the basis is empty
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_action == xlb_pkg::ACT_CLEAR) |=> (r_valid == '0 && r_rank == '0))
        else $error("clear left slots occupied");

    // stored slots keep their leading bit at their own index
    a_lead_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> r_acc[r_idx])
        else $error("stored word has wrong leading bit");

endmodule
